[sv/recency_ordered_tag_list_defines.svh]
// Assertion macros shared by the checker of the recency-ordered tag list.
// Each macro expands to one labeled concurrent assertion with an $error report.
// No dependencies; include by bare file name.
`ifndef RECENCY_ORDERED_TAG_LIST_DEFINES_SVH
`define RECENCY_ORDERED_TAG_LIST_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ROTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ROTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rotl_pkg.sv]
// Shared types and codes for the recency-ordered tag list.
// Used by the sequencer, the top level and the checker. No dependencies.
package rotl_pkg;

    // Fixed widths of the interface fields.
    localparam int TAG_PORT_BITS = 32;
    localparam int CAP_BITS      = 5;
    localparam int COUNT_BITS    = 5;
    localparam int OP_BITS       = 3;

    // Capacity limit after reset.
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REM_FRONT = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REM_BACK  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_FIND      = 3'd4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } rotl_status_t;

    // One result beat as the sequencer presents it.
    typedef struct packed {
        logic                  strobe;
        rotl_status_t          status;
        logic [COUNT_BITS-1:0] count;
        logic                  empty;
        logic                  full;
    } rotl_res_t;

endpackage

[sv/rotl_tag_mem.sv]
// Tag storage for the recency list: one write port, one read port, registered read.
// Parameterized by depth and word width; no package dependencies.
module rotl_tag_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/rotl_seq.sv]
// Sequencer of the recency list: walks the tag memory one slot at a time with a
// shared pointer stepper and tag comparator. Depends on rotl_pkg and rotl_tag_mem.
module rotl_seq
    import rotl_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [OP_BITS-1:0]               op_in,
    input  logic [TAG_PORT_BITS-1:0]         tag_in,
    input  logic [$clog2(DEPTH+1)-1:0]       limit,
    output logic                             busy,
    output rotl_res_t                        res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_CMP = 7'b0000100,
        S_MOVE_RD  = 7'b0001000,
        S_MOVE_WR  = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_FIN      = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [OP_BITS-1:0] op_reg, op_next;
    logic [SW-1:0]    tag_reg, tag_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic             back_reg, back_next;
    rotl_status_t     status_reg, status_next;
    rotl_res_t        res_reg, res_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [SW-1:0]    mem_rdata;

    logic [AW-1:0]    step;
    logic             hit;
    logic             ptr_last;
    logic             step_last;
    logic             is_insert;

    rotl_tag_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared pointer stepper and tag comparator.
    assign step      = back_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
    assign hit       = (mem_rdata == tag_reg);
    assign ptr_last  = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign step_last = ((CW'(step) + CW'(1)) == count_reg);
    assign is_insert = (op_reg == OP_INS_FRONT) || (op_reg == OP_INS_BACK);

    // Memory port control.
    always_comb
    begin
        mem_raddr = (state_reg == S_SCAN_RD) ? ptr_reg : step;
        mem_we    = (state_reg == S_MOVE_WR) || (state_reg == S_PUT);
        mem_waddr = ptr_reg;
        mem_wdata = (state_reg == S_PUT) ? tag_reg : mem_rdata;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        tag_next    = tag_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        back_next   = back_reg;
        status_next = status_reg;
        res_next    = res_reg;
        res_next.strobe = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op_in;
                    tag_next    = tag_in[SW-1:0];
                    status_next = ST_OK;
                    ptr_next    = '0;
                    back_next   = 1'b0;
                    state_next  = S_FIN;
                    case (op_in)
                        OP_INS_FRONT, OP_INS_BACK:
                        begin
                            if (count_reg >= limit)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next  = count_reg[AW-1:0];
                                back_next = 1'b1;
                                if ((op_in == OP_INS_BACK) || (count_reg == '0))
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    state_next = S_MOVE_RD;
                                end
                            end
                        end
                        OP_REM_FRONT, OP_REM_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if ((op_in == OP_REM_BACK) || (count_reg == CW'(1)))
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                state_next = S_MOVE_RD;
                            end
                        end
                        OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end

            // First match wins; a match at the front needs no move.
            S_SCAN_CMP:
            begin
                if (hit)
                begin
                    if (ptr_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        back_next  = 1'b1;
                        state_next = S_MOVE_RD;
                    end
                end
                else if (ptr_last)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else
                begin
                    ptr_next   = step;
                    state_next = S_SCAN_RD;
                end
            end

            S_MOVE_RD:
            begin
                state_next = S_MOVE_WR;
            end

            // Copy the neighbor slot into the current one, then advance.
            S_MOVE_WR:
            begin
                ptr_next = step;
                if (back_reg)
                begin
                    state_next = (step == '0) ? S_PUT : S_MOVE_RD;
                end
                else if (step_last)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MOVE_RD;
                end
            end

            S_PUT:
            begin
                if (is_insert)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = S_FIN;
            end

            // Publish the result beat.
            S_FIN:
            begin
                res_next.strobe = 1'b1;
                res_next.status = status_reg;
                res_next.count  = COUNT_BITS'(count_reg);
                res_next.empty  = (count_reg == '0);
                res_next.full   = (count_reg >= limit);
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers and the result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            res_reg   <= res_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        tag_reg    <= tag_next;
        ptr_reg    <= ptr_next;
        back_reg   <= back_next;
        status_reg <= status_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res  = res_reg;

endmodule

[sv/recency_ordered_tag_list.sv]
// Top level of the recency-ordered tag list: capacity register and result ports.
// Depends on rotl_pkg and rotl_seq.

// LRU recency stack for one cache set, most recent tag in slot 0. Issue an
// operation by raising start while busy is low; one result beat follows on
// done for exactly one cycle and cannot be stalled, so capture it when done is
// high. Tags live in a single-port-read memory and the sequencer moves one
// slot at a time (read, then write). Rejected inserts, removals from the back,
// removals or finds on an empty list and unused codes leave the memory alone;
// insert at the back writes one slot; insert at the front and removal from the
// front shift every entry; find scans from the front and moves a match at a
// later slot to the front. The capacity register may be written only while no
// operation is in flight.
module recency_ordered_tag_list
    import rotl_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int TAG_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_BITS-1:0]       operation,
    input  logic [TAG_PORT_BITS-1:0] tag,
    output logic                     done,
    output logic [1:0]               status,
    output logic [COUNT_BITS-1:0]    entry_count,
    output logic                     empty_flag,
    output logic                     full_flag,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CAP_BITS-1:0]      capacity_limit
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;

    logic [CAP_BITS-1:0] cap_reg;
    logic [LW-1:0]       cap_ext;
    logic [LW-1:0]       lim_wide;
    logic [CW-1:0]       limit;
    rotl_res_t           res;

    // Capacity register; a write beat is taken at any time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            cap_reg <= capacity_limit;
        end
    end

    assign cfg_ready = 1'b1;

    // A limit of zero acts as one, and a limit above the depth as the depth.
    always_comb
    begin
        cap_ext = LW'(cap_reg);
        if (cap_ext == '0)
        begin
            lim_wide = LW'(1);
        end
        else if (cap_ext > LW'(DEPTH))
        begin
            lim_wide = LW'(DEPTH);
        end
        else
        begin
            lim_wide = cap_ext;
        end
        limit = lim_wide[CW-1:0];
    end

    rotl_seq #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op_in  (operation),
        .tag_in (tag),
        .limit  (limit),
        .busy   (busy),
        .res    (res)
    );

    // Result beat.
    assign done        = res.strobe;
    assign status      = res.status;
    assign entry_count = res.count;
    assign empty_flag  = res.empty;
    assign full_flag   = res.full;

endmodule

[sv/rotl_checker.sv]
// Port-level checker for the recency-ordered tag list, bound to the top level.
// Depends on rotl_pkg and recency_ordered_tag_list_defines.svh.
`include "recency_ordered_tag_list_defines.svh"

module rotl_checker
    import rotl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [1:0]            status,
    input logic [COUNT_BITS-1:0] entry_count,
    input logic                  empty_flag,
    input logic                  full_flag
);

    // An accepted operation always makes the block busy in the cycle after the accept.
    `ROTL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")

    // A result beat closes an operation that was in flight.
    `ROTL_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy), "done without work")

    // The empty flag agrees with the reported count, and an empty list is never full.
    `ROTL_ASSERT_SAME(a_empty_count, clk, rst_n, done,
        (empty_flag == (entry_count == '0)) && !(empty_flag && full_flag),
        "empty flag mismatch")

    // A rejected insert leaves the list full; an empty status leaves it empty.
    `ROTL_ASSERT_SAME(a_status_flags, clk, rst_n, done,
        ((status != ST_FULL) || full_flag) && ((status != ST_EMPTY) || empty_flag),
        "status and flags disagree")

endmodule

bind recency_ordered_tag_list rotl_checker u_rotl_checker (.*);

[tb/recency_ordered_tag_list_checker.sv]
`timescale 1ns / 100ps
// Checker for the recency-ordered tag list: models the tag stack, predicts one result
// per accepted beat and compares each result beat field by field.
// Depends on rotl_pkg for the operation codes, status enum and port widths.
module recency_ordered_tag_list_checker
    import rotl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [OP_BITS-1:0]       operation,
    input  logic [TAG_PORT_BITS-1:0] tag,
    input  logic                     done,
    input  logic [1:0]               status,
    input  logic [COUNT_BITS-1:0]    entry_count,
    input  logic                     empty_flag,
    input  logic                     full_flag,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CAP_BITS-1:0]      capacity_limit,
    output int                       mismatches,
    output int                       awaiting,
    output int                       results_seen
);

    // What one operation should report.
    typedef struct {
        rotl_status_t          status;
        logic [COUNT_BITS-1:0] count;
        logic                  empty;
        logic                  full;
    } lru_outcome_t;

    // Shadow copy of the recency stack, slot 0 most recent.
    logic [TAG_PORT_BITS-1:0] recency_tags [DEPTH];
    int                       fill;
    logic [CAP_BITS-1:0]      cap_setting;
    lru_outcome_t             outcome_q [$];
    lru_outcome_t             predicted;
    lru_outcome_t             oldest;

    // A limit of zero behaves as one; anything above the depth behaves as the depth.
    function automatic int active_limit();
        int lim;
        lim = cap_setting;
        if (lim == 0)
        begin
            lim = 1;
        end
        if (lim > DEPTH)
        begin
            lim = DEPTH;
        end
        return lim;
    endfunction

    // Apply one operation to the shadow stack and work out its result.
    task automatic apply_access(input logic [OP_BITS-1:0] op,
                                input logic [TAG_PORT_BITS-1:0] t,
                                output lru_outcome_t res);
        int                       lim;
        int                       n;
        int                       hit_at;
        logic [TAG_PORT_BITS-1:0] moved;
        rotl_status_t             st;
        lim = active_limit();
        n   = fill;
        st  = ST_OK;
        case (op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                // A list at or above the limit rejects inserts and stays as it is.
                if (n >= lim)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    if (op == OP_INS_FRONT)
                    begin
                        for (int i = n; i > 0; i--)
                        begin
                            recency_tags[i] = recency_tags[i - 1];
                        end
                        recency_tags[0] = t;
                    end
                    else
                    begin
                        recency_tags[n] = t;
                    end
                    n++;
                end
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (n == 0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    if (op == OP_REM_FRONT)
                    begin
                        for (int i = 0; i + 1 < n; i++)
                        begin
                            recency_tags[i] = recency_tags[i + 1];
                        end
                    end
                    n--;
                end
            end
            OP_FIND:
            begin
                // Only the match nearest the front moves; the rest keep their order.
                if (n == 0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    hit_at = -1;
                    for (int i = 0; i < n && hit_at < 0; i++)
                    begin
                        if (recency_tags[i] == t)
                        begin
                            hit_at = i;
                        end
                    end
                    if (hit_at < 0)
                    begin
                        st = ST_NOT_FOUND;
                    end
                    else if (hit_at > 0)
                    begin
                        moved = recency_tags[hit_at];
                        for (int i = hit_at; i > 0; i--)
                        begin
                            recency_tags[i] = recency_tags[i - 1];
                        end
                        recency_tags[0] = moved;
                    end
                end
            end
            default:
            begin
                // Spare codes leave the stack alone and report ok.
            end
        endcase
        fill       = n;
        res.status = st;
        res.count  = COUNT_BITS'(n);
        res.empty  = (n == 0);
        res.full   = (n >= lim);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Results are compared before the same edge's new beat is queued, since a result
    // always belongs to an earlier beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outcome_q.delete();
            fill         = 0;
            cap_setting  = CAP_RESET;
            mismatches   = 0;
            awaiting     = 0;
            results_seen = 0;
        end
        else
        begin
            if (done)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing outstanding, status %0d count %0d",
                             $time, status, entry_count);
                end
                else
                begin
                    oldest = outcome_q.pop_front();
                    check_field("status", 32'(oldest.status), 32'(status));
                    check_field("entry_count", 32'(oldest.count), 32'(entry_count));
                    check_field("empty_flag", 32'(oldest.empty), 32'(empty_flag));
                    check_field("full_flag", 32'(oldest.full), 32'(full_flag));
                end
            end
            if (start && !busy)
            begin
                apply_access(operation, tag, predicted);
                outcome_q.push_back(predicted);
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_setting = capacity_limit;
            end
            awaiting = outcome_q.size();
        end
    end

endmodule

[tb/recency_ordered_tag_list_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the recency-ordered tag list: clock, reset, operation and
// capacity stimulus, watchdog and verdict. Depends on rotl_pkg, the block and
// recency_ordered_tag_list_checker.
module recency_ordered_tag_list_tb;
    import rotl_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    localparam int PHASE_ITEMS = 168;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 20;

    // Operation codes the block does not define.
    localparam logic [OP_BITS-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI  = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_BITS-1:0]       operation;
    logic [TAG_PORT_BITS-1:0] tag;
    logic                     done;
    logic [1:0]               status;
    logic [COUNT_BITS-1:0]    entry_count;
    logic                     empty_flag;
    logic                     full_flag;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CAP_BITS-1:0]      capacity_limit;

    logic                     item_taken;
    logic                     cap_taken;
    int                       quiet_cycles;
    int                       ops_issued;
    int                       cap_writes;
    bit                       gaps_on;
    logic [TAG_PORT_BITS-1:0] tag_pool [8];
    int                       mismatches;
    int                       awaiting;
    int                       results_seen;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    recency_ordered_tag_list #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_PORT_BITS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .tag            (tag),
        .done           (done),
        .status         (status),
        .entry_count    (entry_count),
        .empty_flag     (empty_flag),
        .full_flag      (full_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_limit (capacity_limit)
    );

    recency_ordered_tag_list_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .tag            (tag),
        .done           (done),
        .status         (status),
        .entry_count    (entry_count),
        .empty_flag     (empty_flag),
        .full_flag      (full_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .capacity_limit (capacity_limit),
        .mismatches     (mismatches),
        .awaiting       (awaiting),
        .results_seen   (results_seen)
    );

    // Handshakes seen at the rising edge, read back by the driver at the falling edge.
    // Cycles with no beat of any kind feed the watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_taken   <= 1'b0;
            cap_taken    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            item_taken <= start && !busy;
            cap_taken  <= cfg_valid && cfg_ready;
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog: the run is stuck if nothing moves for this long.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no beat for %0d cycles, %0d results still outstanding",
                 $time, QUIET_LIMIT, awaiting);
        $display("CHECK FAILED");
        $finish;
    end

    // Present one operation and hold it until the block takes it. Start stays high
    // afterwards so that back-to-back beats need no extra edge.
    task automatic issue_op(input logic [OP_BITS-1:0] op, input logic [TAG_PORT_BITS-1:0] t);
        while (gaps_on && $urandom_range(0, 99) < 20)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start     = 1'b1;
        operation = op;
        tag       = t;
        do
        begin
            @(negedge clk);
        end
        while (!item_taken);
        ops_issued++;
    endtask

    // Stop issuing and wait for every outstanding result.
    task automatic drain_results();
        start = 1'b0;
        while (awaiting != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_cap(input logic [CAP_BITS-1:0] value);
        cfg_valid      = 1'b1;
        capacity_limit = value;
        do
        begin
            @(negedge clk);
        end
        while (!cap_taken);
        cfg_valid = 1'b0;
        cap_writes++;
    endtask

    // Mostly tags from a small pool so that finds hit and duplicates pile up.
    function automatic logic [TAG_PORT_BITS-1:0] pick_tag();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return tag_pool[$urandom_range(0, 7)];
        end
        else if (roll < 85)
        begin
            return $urandom;
        end
        else if (roll < 92)
        begin
            return '0;
        end
        return '1;
    endfunction

    // One random phase at a given capacity. The mix decides whether the list tends
    // to grow, shrink or hover.
    task automatic run_phase(input logic [CAP_BITS-1:0] cap, input op_mix_t mix,
                             input bit with_gaps);
        int ins_pct;
        int rem_pct;
        int roll;
        drain_results();
        write_cap(cap);
        gaps_on = with_gaps;
        foreach (tag_pool[k])
        begin
            tag_pool[k] = $urandom;
        end
        case (mix)
            MIX_FILL:
            begin
                ins_pct = 55;
                rem_pct = 20;
            end
            MIX_DRAIN:
            begin
                ins_pct = 25;
                rem_pct = 40;
            end
            default:
            begin
                ins_pct = 37;
                rem_pct = 33;
            end
        endcase
        repeat (PHASE_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
            begin
                issue_op($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK, pick_tag());
            end
            else if (roll < ins_pct + rem_pct)
            begin
                issue_op($urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_BACK, $urandom);
            end
            else if (roll < 97)
            begin
                issue_op(OP_FIND, pick_tag());
            end
            else
            begin
                issue_op(OP_BITS'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        operation      = OP_INS_FRONT;
        tag            = '0;
        cfg_valid      = 1'b0;
        capacity_limit = CAP_RESET;
        gaps_on        = 1'b1;
        ops_issued     = 0;
        cap_writes     = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty list: removals and finds report empty.
        issue_op(OP_REM_FRONT, 32'h0000_0000);
        issue_op(OP_REM_BACK, 32'hFFFF_FFFF);
        issue_op(OP_FIND, 32'h0000_0000);
        // Build a list with a duplicate tag and extreme tag values.
        issue_op(OP_INS_FRONT, 32'h0000_0000);
        issue_op(OP_INS_BACK, 32'hFFFF_FFFF);
        issue_op(OP_INS_FRONT, 32'h0000_0000);
        issue_op(OP_INS_BACK, 32'h5A5A_5A5A);
        // Move a deep hit forward, then the nearer of two duplicates, then miss.
        issue_op(OP_FIND, 32'hFFFF_FFFF);
        issue_op(OP_FIND, 32'h0000_0000);
        issue_op(OP_FIND, 32'h1234_5678);
        issue_op(OP_SPARE_LO, 32'hFFFF_FFFF);
        issue_op(OP_SPARE_MID, 32'h0000_0000);
        issue_op(OP_SPARE_HI, 32'hA5A5_A5A5);
        issue_op(OP_REM_FRONT, 32'h0000_0000);
        issue_op(OP_REM_BACK, 32'h0000_0000);

        // A zero limit acts as one and sits below the current count.
        drain_results();
        write_cap(5'd0);
        issue_op(OP_INS_FRONT, 32'h1111_1111);
        issue_op(OP_INS_BACK, 32'h2222_2222);
        issue_op(OP_REM_BACK, 32'h0000_0000);
        issue_op(OP_FIND, 32'hFFFF_FFFF);
        issue_op(OP_REM_FRONT, 32'h0000_0000);
        issue_op(OP_INS_BACK, 32'hA5A5_A5A5);
        issue_op(OP_INS_FRONT, 32'h5A5A_5A5A);

        // Random phases over the capacity range, including values above the depth
        // and a limit lowered under a full list.
        run_phase(5'd16, MIX_FILL, 1'b1);
        run_phase(5'd31, MIX_FILL, 1'b1);
        run_phase(5'd3, MIX_EVEN, 1'b1);
        run_phase(5'd1, MIX_DRAIN, 1'b0);
        run_phase(5'd17, MIX_FILL, 1'b1);
        run_phase(5'd0, MIX_EVEN, 1'b1);
        run_phase(5'd8, MIX_EVEN, 1'b1);
        run_phase(5'd16, MIX_DRAIN, 1'b1);
        run_phase(CAP_BITS'($urandom_range(0, 31)), MIX_EVEN, 1'b1);
        run_phase(5'd31, MIX_FILL, 1'b1);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d operations and %0d results over %0d capacity writes,",
                 ops_issued, results_seen, cap_writes);
        $display("including empty, full, lowered and out-of-range limits and spare codes.");
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rotl_pkg.sv
sv/rotl_tag_mem.sv
sv/rotl_seq.sv
sv/recency_ordered_tag_list.sv
sv/rotl_checker.sv
tb/recency_ordered_tag_list_checker.sv
tb/recency_ordered_tag_list_tb.sv
